@@ rtl/lfps_pkg.sv @@
`timescale 1ns / 1ps

package lfps_pkg;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ONE   = 2'd1;
   localparam logic [1:0] MODE_TWO   = 2'd2;
   localparam logic [1:0] MODE_THREE = 2'd3;

   localparam logic [1:0] CH_A    = 2'd0;
   localparam logic [1:0] CH_B    = 2'd1;
   localparam logic [1:0] CH_C    = 2'd2;
   localparam logic [1:0] CH_NONE = 2'd3;

   localparam logic [13:0] DUR_NONE  = 14'd0;
   localparam logic [13:0] DUR_100   = 14'd100;
   localparam logic [13:0] DUR_1000  = 14'd1000;
   localparam logic [13:0] DUR_2000  = 14'd2000;
   localparam logic [13:0] DUR_4000  = 14'd4000;
   localparam logic [13:0] DUR_6000  = 14'd6000;
   localparam logic [13:0] DUR_10000 = 14'd10000;

   localparam logic [6:0] ELAPSED_MAX = 7'd100;
   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [7:0] LEVEL_ZERO  = 8'd0;
   localparam logic [2:0] PHASE_LAST  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_ADVANCE,
      ST_SETUP,
      ST_DIVIDE,
      ST_SQUARE,
      ST_FOURTH,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ADD,
      CMD_ADVANCE,
      CMD_SETUP,
      CMD_DIV,
      CMD_SQUARE,
      CMD_FOURTH,
      CMD_SCALE,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctrl_type;

   typedef struct packed {
      logic fade_en;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [1:0] ch;
      logic       rise;
   } fade_type;

   function automatic logic [2:0] count_lookup(input logic [1:0] mode);
      logic [2:0] cnt;
      unique case (mode)
         MODE_OFF:   cnt = 3'd1;
         MODE_ONE:   cnt = 3'd4;
         MODE_TWO:   cnt = 3'd5;
         MODE_THREE: cnt = 3'd6;
         default:    cnt = 3'd1;
      endcase
      return cnt;
   endfunction

   function automatic logic [13:0] dur_lookup(input logic [1:0] mode, input logic [2:0] phase);
      logic [13:0] dur;
      dur = DUR_NONE;
      unique case (mode)
         MODE_OFF: begin
            if (phase == 3'd0) dur = DUR_1000;
         end
         MODE_ONE: begin
            unique case (phase)
               3'd0:    dur = DUR_4000;
               3'd1:    dur = DUR_10000;
               3'd2:    dur = DUR_4000;
               3'd3:    dur = DUR_100;
               default: dur = DUR_NONE;
            endcase
         end
         MODE_TWO: begin
            unique case (phase)
               3'd0:    dur = DUR_6000;
               3'd1:    dur = DUR_10000;
               3'd2:    dur = DUR_10000;
               3'd3:    dur = DUR_10000;
               3'd4:    dur = DUR_2000;
               default: dur = DUR_NONE;
            endcase
         end
         MODE_THREE: begin
            if (phase <= PHASE_LAST) dur = DUR_4000;
         end
         default: dur = DUR_NONE;
      endcase
      return dur;
   endfunction

   function automatic fade_type fade_lookup(input logic [1:0] mode, input logic [2:0] phase);
      fade_type fd;
      fd = '{ch: CH_NONE, rise: 1'b0};
      unique case (mode)
         MODE_ONE: begin
            unique case (phase)
               3'd0:    fd = '{ch: CH_A, rise: 1'b1};
               3'd2:    fd = '{ch: CH_A, rise: 1'b0};
               default: fd = '{ch: CH_NONE, rise: 1'b0};
            endcase
         end
         MODE_TWO: begin
            unique case (phase)
               3'd0:    fd = '{ch: CH_A, rise: 1'b1};
               3'd1:    fd = '{ch: CH_B, rise: 1'b1};
               3'd2:    fd = '{ch: CH_A, rise: 1'b0};
               3'd3:    fd = '{ch: CH_B, rise: 1'b0};
               default: fd = '{ch: CH_NONE, rise: 1'b0};
            endcase
         end
         MODE_THREE: begin
            unique case (phase)
               3'd0:    fd = '{ch: CH_A, rise: 1'b1};
               3'd1:    fd = '{ch: CH_C, rise: 1'b0};
               3'd2:    fd = '{ch: CH_B, rise: 1'b1};
               3'd3:    fd = '{ch: CH_A, rise: 1'b0};
               3'd4:    fd = '{ch: CH_C, rise: 1'b1};
               3'd5:    fd = '{ch: CH_B, rise: 1'b0};
               default: fd = '{ch: CH_NONE, rise: 1'b0};
            endcase
         end
         default: fd = '{ch: CH_NONE, rise: 1'b0};
      endcase
      return fd;
   endfunction

endpackage

@@ rtl/lfps_ctrl.sv @@
`timescale 1ns / 1ps

module lfps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lfps_pkg::status_type status,
   output lfps_pkg::ctrl_type ctrl
);
   import lfps_pkg::*;

   localparam logic [3:0] DIV_LAST = 4'd15;

   state_type  state_ff;
   state_type  state_in;
   logic [3:0] div_cnt_ff;
   logic [3:0] div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      ctrl.cmd   = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.cmd = CMD_LOAD;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctrl.cmd = CMD_ADD;
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            ctrl.cmd = CMD_ADVANCE;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            ctrl.cmd   = CMD_SETUP;
            div_cnt_in = '0;
            state_in   = status.fade_en ? ST_DIVIDE : ST_EMIT;
         end
         ST_DIVIDE: begin
            ctrl.cmd   = CMD_DIV;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == DIV_LAST) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            ctrl.cmd = CMD_SQUARE;
            state_in = ST_FOURTH;
         end
         ST_FOURTH: begin
            ctrl.cmd = CMD_FOURTH;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            ctrl.cmd = CMD_SCALE;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            ctrl.cmd = CMD_EMIT;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && div_cnt_ff == DIV_LAST) |=> state_ff == ST_SQUARE)
      else $error("divide did not end after 16 steps");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIVIDE && state_in == ST_DIVIDE) |-> div_cnt_in == 4'd0)
      else $error("divide entered with stale count");

endmodule

@@ rtl/lfps_datapath.sv @@
`timescale 1ns / 1ps

module lfps_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lfps_pkg::ctrl_type   ctrl,
   output lfps_pkg::status_type status,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_write_data,
   input  logic [6:0]           req_elapsed_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_level_a,
   output logic [7:0]           rsp_level_b,
   output logic [7:0]           rsp_level_c,
   output logic [2:0]           rsp_phase_now,
   output logic                 rsp_phase_advanced
);
   import lfps_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  phase_ff, phase_in;
   logic [13:0] timer_ff, timer_in;
   logic [7:0]  level_ff [3];
   logic [7:0]  level_in [3];
   logic [6:0]  elapsed_ff, elapsed_in;
   logic        adv_ff, adv_in;
   logic [13:0] dur_ff, dur_in;
   logic [1:0]  fade_ch_ff, fade_ch_in;
   logic        rise_ff, rise_in;
   logic        sat_ff, sat_in;
   logic [13:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;
   logic        gmax_ff, gmax_in;
   logic [63:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_a_ff, rsp_a_in;
   logic [7:0]  rsp_b_ff, rsp_b_in;
   logic [7:0]  rsp_c_ff, rsp_c_in;
   logic [2:0]  rsp_phase_ff, rsp_phase_in;
   logic        rsp_adv_ff, rsp_adv_in;

   logic [6:0]  elapsed_sat;
   logic [13:0] dur_now;
   fade_type    fade_now;
   logic [2:0]  phase_next;
   logic [14:0] div_shift;
   logic [14:0] div_diff;
   logic        div_take;
   logic [15:0] f_val;
   logic [16:0] g_val;
   logic [31:0] mul_op;
   logic [63:0] mul_res;
   logic [71:0] scaled;
   logic [7:0]  fade_level;

   assign elapsed_sat = (elapsed_ff > ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ff;
   assign dur_now     = dur_lookup(mode_ff, phase_ff);
   assign fade_now    = fade_lookup(mode_ff, phase_ff);
   assign phase_next  = ((phase_ff + 3'd1) >= count_lookup(mode_ff)) ? 3'd0 : phase_ff + 3'd1;

   assign div_shift = {rem_ff, 1'b0};
   assign div_diff  = div_shift - {1'b0, dur_ff};
   assign div_take  = (div_shift >= {1'b0, dur_ff});

   assign f_val   = sat_ff ? 16'hFFFF : quot_ff;
   assign g_val   = rise_ff ? {1'b0, f_val} : 17'h1_0000 - {1'b0, f_val};
   assign mul_op  = (ctrl.cmd == CMD_SQUARE) ? {16'h0000, g_val[15:0]} : prod_ff[31:0];
   assign mul_res = mul_op * mul_op;

   // 255 * p / 2^64, truncated
   assign scaled     = {prod_ff, 8'h00} - {8'h00, prod_ff};
   assign fade_level = gmax_ff ? LEVEL_MAX : scaled[71:64];

   assign status.fade_en  = (fade_now.ch != CH_NONE) && (dur_now != DUR_NONE);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      level_in   = level_ff;
      elapsed_in = elapsed_ff;
      adv_in     = adv_ff;
      dur_in     = dur_ff;
      fade_ch_in = fade_ch_ff;
      rise_in    = rise_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      gmax_in    = gmax_ff;
      prod_in    = prod_ff;
      if (csr_write_enable) begin
         mode_in     = csr_write_data;
         phase_in    = '0;
         timer_in    = '0;
         level_in[0] = LEVEL_ZERO;
         level_in[1] = LEVEL_ZERO;
         level_in[2] = (csr_write_data == MODE_THREE) ? LEVEL_MAX : LEVEL_ZERO;
      end else begin
         unique case (ctrl.cmd)
            CMD_LOAD: elapsed_in = req_elapsed_ms;
            CMD_ADD: begin
               timer_in = timer_ff + {7'd0, elapsed_sat};
               if (phase_ff >= count_lookup(mode_ff)) phase_in = '0;
            end
            CMD_ADVANCE: begin
               adv_in = 1'b0;
               if (timer_ff > dur_now) begin
                  adv_in   = 1'b1;
                  timer_in = timer_ff - dur_now;
                  phase_in = phase_next;
                  unique case (mode_ff)
                     MODE_ONE: begin
                        if (phase_next == 3'd0) level_in[0] = LEVEL_ZERO;
                     end
                     MODE_TWO: begin
                        unique case (phase_next)
                           3'd0, 3'd4: begin
                              level_in[0] = LEVEL_ZERO;
                              level_in[1] = LEVEL_ZERO;
                           end
                           3'd1: begin
                              level_in[0] = LEVEL_MAX;
                              level_in[1] = LEVEL_ZERO;
                           end
                           3'd2: begin
                              level_in[0] = LEVEL_MAX;
                              level_in[1] = LEVEL_MAX;
                           end
                           3'd3: begin
                              level_in[0] = LEVEL_ZERO;
                              level_in[1] = LEVEL_MAX;
                           end
                           default: ;
                        endcase
                     end
                     MODE_THREE: begin
                        if (phase_next == 3'd0) begin
                           level_in[0] = LEVEL_ZERO;
                           level_in[1] = LEVEL_ZERO;
                           level_in[2] = LEVEL_MAX;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            CMD_SETUP: begin
               dur_in     = dur_now;
               fade_ch_in = fade_now.ch;
               rise_in    = fade_now.rise;
               sat_in     = (timer_ff >= dur_now);
               rem_in     = timer_ff;
               quot_in    = '0;
            end
            CMD_DIV: begin
               rem_in  = div_take ? div_diff[13:0] : div_shift[13:0];
               quot_in = {quot_ff[14:0], div_take};
            end
            CMD_SQUARE: begin
               gmax_in = g_val[16];
               prod_in = mul_res;
            end
            CMD_FOURTH: prod_in = mul_res;
            CMD_SCALE: begin
               unique case (fade_ch_ff)
                  CH_A:    level_in[0] = fade_level;
                  CH_B:    level_in[1] = fade_level;
                  CH_C:    level_in[2] = fade_level;
                  default: ;
               endcase
            end
            CMD_NONE, CMD_EMIT: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_adv_in   = rsp_adv_ff;
      if (ctrl.cmd == CMD_EMIT && status.out_free) begin
         rsp_valid_in = 1'b1;
         rsp_a_in     = level_ff[0];
         rsp_b_in     = level_ff[1];
         rsp_c_in     = level_ff[2];
         rsp_phase_in = phase_ff;
         rsp_adv_in   = adv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         phase_ff     <= '0;
         timer_ff     <= '0;
         level_ff[0]  <= LEVEL_ZERO;
         level_ff[1]  <= LEVEL_ZERO;
         level_ff[2]  <= LEVEL_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      adv_ff       <= adv_in;
      dur_ff       <= dur_in;
      fade_ch_ff   <= fade_ch_in;
      rise_ff      <= rise_in;
      sat_ff       <= sat_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      gmax_ff      <= gmax_in;
      prod_ff      <= prod_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_adv_ff   <= rsp_adv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_a        = rsp_a_ff;
   assign rsp_level_b        = rsp_b_ff;
   assign rsp_level_c        = rsp_c_ff;
   assign rsp_phase_now      = rsp_phase_ff;
   assign rsp_phase_advanced = rsp_adv_ff;

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == CMD_DIV && !sat_ff) |-> rem_ff < dur_ff)
      else $error("divider remainder out of range");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < count_lookup(mode_ff))
      else $error("phase beyond mode phase count");

endmodule

@@ rtl/led_fade_phase_sequencer_core.sv @@
`timescale 1ns / 1ps
// A req beat steps through load, add, advance and setup; if the phase fades a channel,
// a 16-step restoring divide, two passes of one shared 32x32 multiplier and a scale
// follow, then emit, which waits while a stalled rsp beat is held; one tick in flight.
// The rsp register holds a finished beat while the next req beat is taken.
// Synchronous active-high reset: mode 0, phase 0, timer 0, all levels 0, no rsp pending.

module led_fade_phase_sequencer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_elapsed_ms,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_level_a,
   output logic [7:0] rsp_level_b,
   output logic [7:0] rsp_level_c,
   output logic [2:0] rsp_phase_now,
   output logic       rsp_phase_advanced
);
   import lfps_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   lfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   lfps_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_elapsed_ms     (req_elapsed_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level_a        (rsp_level_a),
      .rsp_level_b        (rsp_level_b),
      .rsp_level_c        (rsp_level_c),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_phase_advanced (rsp_phase_advanced)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second req beat taken while a tick is in flight");

   a_rsp_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase_now <= PHASE_LAST)
      else $error("rsp phase out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == CMD_EMIT && rsp_valid && rsp_stall) |=> ctrl.cmd == CMD_EMIT)
      else $error("result dropped while rsp stalled");

endmodule
